/* sv/pak_pkg.sv */
// Package for the planar arm kinematics block.
// Holds CORDIC constants, latencies, result types and the round/saturate helper.
// No dependencies.
package pak_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_LAT = CORDIC_STEPS + 5;
    localparam int SUM_LAT = 4;
    localparam int NUM_JOINTS = 4;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [17:0] trig_t;
    typedef logic signed [17:0] rsum_t;

    typedef struct packed {
        logic [31:0] jx;
        logic [31:0] jy;
        logic [31:0] dx;
        logic [31:0] dy;
    } col_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        col_t [NUM_JOINTS-1:0] col;
    } res_t;

    function automatic logic signed [33:0] arc_step(input int i);
        case (i)
            0: return 34'sd536870912;
            1: return 34'sd316933406;
            2: return 34'sd167458907;
            3: return 34'sd85004756;
            4: return 34'sd42667331;
            5: return 34'sd21354465;
            6: return 34'sd10679838;
            7: return 34'sd5340245;
            8: return 34'sd2670163;
            9: return 34'sd1335087;
            10: return 34'sd667544;
            11: return 34'sd333772;
            12: return 34'sd166886;
            13: return 34'sd83443;
            14: return 34'sd41722;
            15: return 34'sd20861;
            default: return 34'sd0;
        endcase
    endfunction

    function automatic logic [31:0] rnd_sat(input logic signed [63:0] v, input int sh);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (r < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return r[31:0];
        end
    endfunction

endpackage

/* sv/planar_arm_kinematics.sv */
// Planar four link arm: tip position, Jacobian and Jacobian rate per column.
// Depends on pak_pkg, pak_trig and pak_sum.
//
// Usage:
//   s_ channel: one request per input item. s_tdata holds the four joint
//   angles then the four joint rates; s_tuser holds the frame index.
//   m_ channel: four requests per item, columns 0 to 3 in order, m_tuser
//   carrying the column index and m_tlast high on column 3.
//   cfg channel: writes one link length register, always ready.
// The first column passes the input stage, the trig lanes, pak_sum and the
// output register; the other columns follow one per cycle while m_tready is high.
// The output stage sends the four columns of an item over the m_ channel and
// takes no new item until the last column has been accepted.
// The whole pipeline advances together; until the receiver accepts the
// last column, nothing moves and s_tready is low. Nothing is lost.
// Reset clears all valid bits and sets every link length to 256 (1.0).
module planar_arm_kinematics #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // angle_zero, angle_one, angle_two, angle_three, rate_zero..rate_three
    input  logic [127:0]  s_tdata,
    // frame_index
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // position_x, position_y, jacobian_x, jacobian_y, jacobian_rate_x, jacobian_rate_y
    output logic [191:0]  m_tdata,
    // column_index
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    localparam int TL = pak_pkg::TRIG_LAT;

    logic [15:0] len_reg [4];
    logic ce;
    logic ser_valid_reg;
    logic [1:0] col_reg;
    pak_pkg::res_t ser_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) len_reg[i] <= 16'd256;
        end else if (cfg_valid) begin
            len_reg[cfg_index] <= cfg_data;
        end
    end

    assign ce = !ser_valid_reg || (m_tready && col_reg == 2'd3);
    assign s_tready = ce;

    // Input stage: phase sums and rate sums
    logic v0_reg;
    logic [15:0] ph_reg [4];
    pak_pkg::rsum_t rs_reg [4];
    logic [1:0] f0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph_reg[0] <= s_tdata[15:0];
            ph_reg[1] <= s_tdata[15:0] + s_tdata[31:16];
            ph_reg[2] <= s_tdata[15:0] + s_tdata[31:16] + s_tdata[47:32];
            ph_reg[3] <= s_tdata[15:0] + s_tdata[31:16] + s_tdata[47:32] + s_tdata[63:48];
            rs_reg[0] <= 18'(signed'(s_tdata[79:64]));
            rs_reg[1] <= 18'(signed'(s_tdata[79:64])) + 18'(signed'(s_tdata[95:80]));
            rs_reg[2] <= 18'(signed'(s_tdata[79:64])) + 18'(signed'(s_tdata[95:80]))
                       + 18'(signed'(s_tdata[111:96]));
            rs_reg[3] <= 18'(signed'(s_tdata[79:64])) + 18'(signed'(s_tdata[95:80]))
                       + 18'(signed'(s_tdata[111:96])) + 18'(signed'(s_tdata[127:112]));
            f0_reg <= s_tuser;
        end
    end

    pak_pkg::trig_t sn [4];
    pak_pkg::trig_t cs [4];

    for (genvar j = 0; j < 4; j++) begin : g_trig
        pak_trig #(.TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_trig (
            .aclk   (aclk),
            .ce     (ce),
            .phase  (ph_reg[j]),
            .sine   (sn[j]),
            .cosine (cs[j])
        );
    end

    // Side data delay matching the trig lanes
    logic [TL-1:0] vd_reg;
    logic [1:0] fd_reg [TL];
    pak_pkg::rsum_t rsd_reg [TL][4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (ce) begin
            vd_reg <= {vd_reg[TL-2:0], v0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fd_reg[0] <= f0_reg;
            rsd_reg[0] <= rs_reg;
            for (int i = 1; i < TL; i++) begin
                fd_reg[i] <= fd_reg[i-1];
                rsd_reg[i] <= rsd_reg[i-1];
            end
        end
    end

    logic sum_valid;
    pak_pkg::res_t sum_res;

    pak_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vd_reg[TL-1]),
        .frame     (fd_reg[TL-1]),
        .sn        (sn),
        .cs        (cs),
        .rs        (rsd_reg[TL-1]),
        .len       (len_reg),
        .out_valid (sum_valid),
        .res       (sum_res)
    );

    // Output stage: one column per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            col_reg <= 2'd0;
        end else if (ce) begin
            ser_valid_reg <= sum_valid;
            col_reg <= 2'd0;
        end else if (m_tready) begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ser_reg <= sum_res;
        end
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tuser = col_reg;
    assign m_tlast = (col_reg == 2'd3);
    assign m_tdata = {ser_reg.col[col_reg].dy, ser_reg.col[col_reg].dx,
                      ser_reg.col[col_reg].jy, ser_reg.col[col_reg].jx,
                      ser_reg.py, ser_reg.px};

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_columns_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 2'd1)
        else $error("column sequence broken");
    a_no_input_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while item incomplete");
endmodule

/* sv/pak_trig.sv */
// One sine/cosine lane: phase quantization to the table grid, then a 16 stage CORDIC.
// Depends on pak_pkg. Registered in turn: the quantization steps, the CORDIC stages and the output.
module pak_trig #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic [15:0]        phase,
    output pak_pkg::trig_t     sine,
    output pak_pkg::trig_t     cosine
);
    localparam int KW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [KW-1:0] NC = KW'(TABLE_ENTRIES);
    localparam logic [40:0] RECIP = 41'((64'd1 << 48) / TABLE_ENTRIES);
    localparam int N = pak_pkg::CORDIC_STEPS;

    logic [KW-1:0] k1_reg, k2_reg, k3_reg;
    logic [31:0] q2_reg, q3_reg;
    logic [KW+31:0] qn3_reg;

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic flip_reg [N+1];

    logic [KW+15:0] p1;
    logic [KW+40:0] p2;
    logic [KW+31:0] rem;
    logic [31:0] th, th2;
    logic flip_next;

    assign p1 = phase * NC;
    assign p2 = k1_reg * RECIP;
    assign rem = {k3_reg, 32'd0} - qn3_reg;
    assign th = q3_reg + ((rem >= (KW+32)'(NC)) ? 32'd1 : 32'd0);
    assign flip_next = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
    assign th2 = flip_next ? th - 32'h8000_0000 : th;

    always_ff @(posedge aclk) begin
        if (ce) begin
            k1_reg <= p1[KW+15:16];
            k2_reg <= k1_reg;
            q2_reg <= p2[47:16];
            k3_reg <= k2_reg;
            q3_reg <= q2_reg;
            qn3_reg <= q2_reg * NC;
            x_reg[0] <= pak_pkg::CORDIC_GAIN;
            y_reg[0] <= 34'sd0;
            z_reg[0] <= 34'(signed'(th2));
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - pak_pkg::arc_step(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + pak_pkg::arc_step(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    logic signed [33:0] xr, yr;
    assign xr = (x_reg[N] + 34'sd32768) >>> 16;
    assign yr = (y_reg[N] + 34'sd32768) >>> 16;

    always_ff @(posedge aclk) begin
        if (ce) begin
            cosine <= flip_reg[N] ? -xr[17:0] : xr[17:0];
            sine <= flip_reg[N] ? -yr[17:0] : yr[17:0];
        end
    end
endmodule

/* sv/pak_sum.sv */
// Link products, masked suffix sums per column, rounding and saturation.
// Depends on pak_pkg. Registered in turn: link products, masked products, suffix sums, results.
module pak_sum (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [1:0]         frame,
    input  pak_pkg::trig_t     sn [4],
    input  pak_pkg::trig_t     cs [4],
    input  pak_pkg::rsum_t     rs [4],
    input  logic [15:0]        len [4],
    output logic               out_valid,
    output pak_pkg::res_t      res
);
    logic [2:0] v_reg;
    logic [1:0] f1_reg;
    logic signed [34:0] lc1_reg [4], ls1_reg [4];
    pak_pkg::rsum_t rs1_reg [4];
    logic signed [34:0] lc2_reg [4], ls2_reg [4];
    logic signed [52:0] lrc2_reg [4], lrs2_reg [4];
    logic signed [37:0] slc_reg [4], sls_reg [4];
    logic signed [55:0] slrc_reg [4], slrs_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            out_valid <= 1'b0;
        end else if (ce) begin
            v_reg <= {v_reg[1:0], in_valid};
            out_valid <= v_reg[2];
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (ce) begin
                lc1_reg[j] <= $signed({1'b0, len[j]}) * cs[j];
                ls1_reg[j] <= $signed({1'b0, len[j]}) * sn[j];
                rs1_reg[j] <= rs[j];
                if (j <= f1_reg) begin
                    lc2_reg[j] <= lc1_reg[j];
                    ls2_reg[j] <= ls1_reg[j];
                    lrc2_reg[j] <= lc1_reg[j] * rs1_reg[j];
                    lrs2_reg[j] <= ls1_reg[j] * rs1_reg[j];
                end else begin
                    lc2_reg[j] <= '0;
                    ls2_reg[j] <= '0;
                    lrc2_reg[j] <= '0;
                    lrs2_reg[j] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_reg <= frame;
            slc_reg[3] <= 38'(lc2_reg[3]);
            sls_reg[3] <= 38'(ls2_reg[3]);
            slrc_reg[3] <= 56'(lrc2_reg[3]);
            slrs_reg[3] <= 56'(lrs2_reg[3]);
            slc_reg[2] <= 38'(lc2_reg[3]) + 38'(lc2_reg[2]);
            sls_reg[2] <= 38'(ls2_reg[3]) + 38'(ls2_reg[2]);
            slrc_reg[2] <= 56'(lrc2_reg[3]) + 56'(lrc2_reg[2]);
            slrs_reg[2] <= 56'(lrs2_reg[3]) + 56'(lrs2_reg[2]);
            slc_reg[1] <= 38'(lc2_reg[3]) + 38'(lc2_reg[2]) + 38'(lc2_reg[1]);
            sls_reg[1] <= 38'(ls2_reg[3]) + 38'(ls2_reg[2]) + 38'(ls2_reg[1]);
            slrc_reg[1] <= 56'(lrc2_reg[3]) + 56'(lrc2_reg[2]) + 56'(lrc2_reg[1]);
            slrs_reg[1] <= 56'(lrs2_reg[3]) + 56'(lrs2_reg[2]) + 56'(lrs2_reg[1]);
            slc_reg[0] <= 38'(lc2_reg[3]) + 38'(lc2_reg[2]) + 38'(lc2_reg[1])
                        + 38'(lc2_reg[0]);
            sls_reg[0] <= 38'(ls2_reg[3]) + 38'(ls2_reg[2]) + 38'(ls2_reg[1])
                        + 38'(ls2_reg[0]);
            slrc_reg[0] <= 56'(lrc2_reg[3]) + 56'(lrc2_reg[2]) + 56'(lrc2_reg[1])
                         + 56'(lrc2_reg[0]);
            slrs_reg[0] <= 56'(lrs2_reg[3]) + 56'(lrs2_reg[2]) + 56'(lrs2_reg[1])
                         + 56'(lrs2_reg[0]);
            res.px <= pak_pkg::rnd_sat(64'(slc_reg[0]), 6);
            res.py <= pak_pkg::rnd_sat(64'(sls_reg[0]), 6);
            for (int c = 0; c < 4; c++) begin
                res.col[c].jx <= pak_pkg::rnd_sat(-64'(sls_reg[c]), 6);
                res.col[c].jy <= pak_pkg::rnd_sat(64'(slc_reg[c]), 6);
                res.col[c].dx <= pak_pkg::rnd_sat(-64'(slrc_reg[c]), 18);
                res.col[c].dy <= pak_pkg::rnd_sat(-64'(slrs_reg[c]), 18);
            end
        end
    end
endmodule
